@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros. They are clocked on clk_i and disabled
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

@@ rtl/core/anfb_pkg.sv @@
// ----------------------------------------------------------------------------
// anfb_pkg
// Constants and helpers for the ack/nak reply frame builder.
// ----------------------------------------------------------------------------
package anfb_pkg;

  localparam int unsigned AddrW    = 24;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 4;   // frame length 4..10
  localparam int unsigned MaxFrame = 10;
  localparam int unsigned BodyLen  = 9;   // frame without checksum byte

  localparam logic [7:0] SYNC_CODE = 8'h54;
  localparam logic [7:0] EDM_CODE  = 8'h20;
  localparam logic [1:0] TYPE_ACK  = 2'd2;
  localparam logic [1:0] TYPE_NAK  = 2'd3;

  // Number of bytes an address occupies in the frame.
  function automatic logic [1:0] addr_bytes(input logic [AddrW-1:0] a);
    logic [1:0] n;
    if (a == '0) begin
      n = 2'd0;
    end else if (a[23:8] == '0) begin
      n = 2'd1;
    end else if (a[23:16] == '0) begin
      n = 2'd2;
    end else begin
      n = 2'd3;
    end
    return n;
  endfunction

  // Left-align the used bytes of an address, unused low bytes zero.
  function automatic logic [AddrW-1:0] addr_align(input logic [AddrW-1:0] a,
                                                  input logic [1:0] n);
    logic [AddrW-1:0] r;
    case (n)
      2'd0:    r = '0;
      2'd1:    r = {a[7:0], 16'h0000};
      2'd2:    r = {a[15:0], 8'h00};
      2'd3:    r = a;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/ack_nak_frame_builder.sv @@
// ----------------------------------------------------------------------------
// ack_nak_frame_builder
// Builds an ack/nak reply frame per request and streams it out byte by byte.
// ----------------------------------------------------------------------------
// Usage:
//  - Request beat: drive is_nak_i, partner_address_i, room_left_i with start
//    high; it is taken at a rising edge where busy is low.
//  - Config: cfg_we_i high writes cfg_wdata_i into the own address register
//    (reset 0). Write only while no frame is in flight.
//  - Result beats: frame_byte_o/refused_o/last_byte_o are valid for one cycle
//    while strobe_o is high. last_byte_o marks the checksum byte or the
//    single refused beat. The receiver cannot stall.
//  - Path: a request passes three pipeline registers (stages 1 to 3), then
//    the output shifter, before its first byte strobes.
//  - Throughput: one byte per cycle inside a frame; a request holds the output
//    shifter for its frame length, 4 to 10 bytes, or one beat when refused.
//    Frames go out back to back when the next waits in stage 3. The byte-wide
//    output shifter sets this rate; up to three further requests queue in the
//    pipeline, then busy stays high until the shifter loads the oldest one.
//  - Reset: all valid bits clear and the own address returns to 0.
// ----------------------------------------------------------------------------
module ack_nak_frame_builder
  import anfb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic             is_nak_i,
  input  logic [AddrW-1:0] partner_address_i,
  input  logic [7:0]       room_left_i,
  input  logic             cfg_we_i,
  input  logic [AddrW-1:0] cfg_wdata_i,
  output logic             strobe_o,
  output logic [7:0]       frame_byte_o,
  output logic             refused_o,
  output logic             last_byte_o
);

  // Own address register
  logic [AddrW-1:0] own_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q <= '0;
    end else if (cfg_we_i) begin
      own_q <= cfg_wdata_i;
    end
  end

  // Pipeline flow control
  logic s1_valid_q, s2_valid_q, s3_valid_q, ser_valid_q;
  logic s1_ready, s2_ready, s3_ready, ser_load, accept;
  logic [LenW-1:0] ser_rem_q;

  assign ser_load = s3_valid_q && (!ser_valid_q || (ser_rem_q == LenW'(1)));
  assign s3_ready = !s3_valid_q || ser_load;
  assign s2_ready = !s2_valid_q || s3_ready;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign busy     = !s1_ready;
  assign accept   = start && !busy;

  // Stage 1: capture request and own address
  logic             s1_nak_q;
  logic [AddrW-1:0] s1_peer_q, s1_own_q;
  logic [7:0]       s1_room_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_nak_q  <= is_nak_i;
      s1_peer_q <= partner_address_i;
      s1_own_q  <= own_q;
      s1_room_q <= room_left_i;
    end
  end

  // Stage 2: byte counts, length, room check, header byte, address byte sums
  logic [1:0]       s2_pn_d, s2_on_d;
  logic [LenW-1:0]  s2_len_d;
  logic             s2_ref_d;
  logic [7:0]       s2_hdr_d;
  logic [7:0]       s2_psum_d, s2_osum_d;
  logic [1:0]       s2_pn_q, s2_on_q;
  logic [LenW-1:0]  s2_len_q;
  logic             s2_ref_q;
  logic [7:0]       s2_hdr_q;
  logic [7:0]       s2_psum_q, s2_osum_q;
  logic [AddrW-1:0] s2_peer_q, s2_own_q;

  always_comb begin
    s2_pn_d  = addr_bytes(s1_peer_q);
    s2_on_d  = addr_bytes(s1_own_q);
    s2_len_d = LenW'(4) + {2'b00, s2_pn_d} + {2'b00, s2_on_d};
    s2_ref_d = s1_room_q < {4'b0000, s2_len_d};
    s2_hdr_d = {s2_pn_d, s2_on_d, 2'b00, (s1_nak_q ? TYPE_NAK : TYPE_ACK)};
    // unused high address bytes are zero, so all three bytes can be summed
    s2_psum_d = s1_peer_q[7:0] + s1_peer_q[15:8] + s1_peer_q[23:16];
    s2_osum_d = s1_own_q[7:0] + s1_own_q[15:8] + s1_own_q[23:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_pn_q   <= s2_pn_d;
      s2_on_q   <= s2_on_d;
      s2_len_q  <= s2_len_d;
      s2_ref_q  <= s2_ref_d;
      s2_hdr_q  <= s2_hdr_d;
      s2_psum_q <= s2_psum_d;
      s2_osum_q <= s2_osum_d;
      s2_peer_q <= s1_peer_q;
      s2_own_q  <= s1_own_q;
    end
  end

  // Stage 3: frame body, addresses packed MSB first after the fixed bytes
  logic [AddrW-1:0]           peer_al, own_al;
  logic [2*AddrW-1:0]         addr_cat;
  logic [BodyLen-1:0][7:0]    s3_body_d, s3_body_q;
  logic [7:0]                 s3_cks_d, s3_cks_q;
  logic [LenW-1:0]            s3_len_q;
  logic                       s3_ref_q;

  always_comb begin
    peer_al = addr_align(s2_peer_q, s2_pn_q);
    own_al  = addr_align(s2_own_q, s2_on_q);
    case (s2_pn_q)
      2'd0:    addr_cat = {own_al, 24'h000000};
      2'd1:    addr_cat = {peer_al[23:16], own_al, 16'h0000};
      2'd2:    addr_cat = {peer_al[23:8], own_al, 8'h00};
      2'd3:    addr_cat = {peer_al, own_al};
      default: addr_cat = '0;
    endcase
    s3_body_d[0] = SYNC_CODE;
    s3_body_d[1] = s2_hdr_q;
    s3_body_d[2] = EDM_CODE;
    for (int k = 0; k < 6; k++) begin
      s3_body_d[k+3] = addr_cat[2*AddrW-1-8*k -: 8];
    end
    // checksum over sync, header, fixed byte and both addresses
    s3_cks_d = SYNC_CODE + EDM_CODE + s2_hdr_q + s2_psum_q + s2_osum_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_valid_q) begin
      s3_body_q <= s3_body_d;
      s3_cks_q  <= s3_cks_d;
      s3_len_q  <= s2_len_q;
      s3_ref_q  <= s2_ref_q;
    end
  end

  // Checksum insertion at the frame tail; unused body bytes are zero
  logic [MaxFrame-1:0][7:0]    frame;

  always_comb begin
    for (int k = 0; k < MaxFrame; k++) begin
      frame[k] = '0;
      if (k < BodyLen) begin
        frame[k] = s3_body_q[k];
      end
      if (LenW'(k + 1) == s3_len_q) begin
        frame[k] = frame[k] | s3_cks_q;
      end
    end
    if (s3_ref_q) begin
      frame = '0;
    end
  end

  // Output shifter: one byte per cycle, next frame loads on the last byte
  logic [MaxFrame-1:0][7:0] ser_bytes_q;
  logic                     ser_ref_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_valid_q <= 1'b0;
      ser_rem_q   <= '0;
    end else if (ser_load) begin
      ser_valid_q <= 1'b1;
      ser_rem_q   <= s3_ref_q ? LenW'(1) : s3_len_q;
    end else if (ser_valid_q) begin
      ser_valid_q <= ser_rem_q != LenW'(1);
      ser_rem_q   <= ser_rem_q - LenW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_load) begin
      ser_bytes_q <= frame;
      ser_ref_q   <= s3_ref_q;
    end else if (ser_valid_q) begin
      ser_bytes_q <= {8'h00, ser_bytes_q[MaxFrame-1:1]};
    end
  end

  assign strobe_o     = ser_valid_q;
  assign frame_byte_o = ser_bytes_q[0];
  assign refused_o    = ser_valid_q && ser_ref_q;
  assign last_byte_o  = ser_valid_q && (ser_rem_q == LenW'(1));

endmodule

@@ rtl/core/anfb_checker.sv @@
// ----------------------------------------------------------------------------
// anfb_checker
// Port-level checks on the result beats of the frame builder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module anfb_checker
  import anfb_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       strobe_o,
  input logic [7:0] frame_byte_o,
  input logic       refused_o,
  input logic       last_byte_o
);

  // A refused beat is a lone zero byte that also ends its frame
  `ASSERT_CLK(a_refused_form, refused_o |-> (strobe_o && last_byte_o && frame_byte_o == 8'h00), "refused beat malformed")

  // Frame bytes come out without gaps until the last one
  `ASSERT_CLK(a_no_gap, (strobe_o && !last_byte_o) |=> strobe_o, "gap inside a frame")

  // Every built frame opens with the sync byte
  `ASSERT_CLK(a_sync_first, ((!strobe_o || last_byte_o) ##1 (strobe_o && !refused_o)) |-> (frame_byte_o == SYNC_CODE), "frame does not start with sync")

  // Flags only ride on a strobed beat
  `ASSERT_NEVER(a_flags_idle, !strobe_o && (last_byte_o || refused_o), "flag without strobe")

endmodule

bind ack_nak_frame_builder anfb_checker u_anfb_checker (.*);
